@@ hdl/digw_pkg.sv @@
`default_nettype none
package digw_pkg;

	localparam int WIN_DEPTH = 5;
	localparam int NUM_WORDS = 10;
	localparam int CNT_W = $clog2(WIN_DEPTH + 1);
	localparam logic [7:0] DIGIT_BASE = 8'h30;

	typedef logic [WIN_DEPTH-1:0][7:0] win_t;

	typedef struct packed {
		logic [CNT_W-1:0] shift;
		logic             load;
	} cell_ctl_t;

	typedef struct packed {
		logic [7:0]       res_byte;
		logic [CNT_W-1:0] used;
	} match_t;

	localparam logic [7:0] WORD_TAB [NUM_WORDS][WIN_DEPTH] = '{
		'{"z", "e", "r", "o", 8'h00},
		'{"o", "n", "e", 8'h00, 8'h00},
		'{"t", "w", "o", 8'h00, 8'h00},
		'{"t", "h", "r", "e", "e"},
		'{"f", "o", "u", "r", 8'h00},
		'{"f", "i", "v", "e", 8'h00},
		'{"s", "i", "x", 8'h00, 8'h00},
		'{"s", "e", "v", "e", "n"},
		'{"e", "i", "g", "h", "t"},
		'{"n", "i", "n", "e", 8'h00}
	};

	localparam logic [CNT_W-1:0] WORD_LEN [NUM_WORDS] = '{
		CNT_W'(4), CNT_W'(3), CNT_W'(3), CNT_W'(5), CNT_W'(4),
		CNT_W'(4), CNT_W'(3), CNT_W'(5), CNT_W'(5), CNT_W'(4)
	};

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c | 8'h20;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ hdl/digw_cell.sv @@
`default_nettype none
module digw_cell (
	input  wire logic                clk,
	input  wire digw_pkg::cell_ctl_t ctl,
	input  wire logic [7:0]          up1,
	input  wire logic [7:0]          up3,
	input  wire logic [7:0]          up4,
	input  wire logic [7:0]          in_byte,
	output logic [7:0]               byte_q
);

	logic [7:0] shifted;

	always_comb begin
		case (ctl.shift)
			digw_pkg::CNT_W'(0): shifted = byte_q;
			digw_pkg::CNT_W'(1): shifted = up1;
			digw_pkg::CNT_W'(3): shifted = up3;
			digw_pkg::CNT_W'(4): shifted = up4;
			default:             shifted = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		byte_q <= ctl.load ? in_byte : shifted;
	end

endmodule
`default_nettype wire

@@ hdl/digw_match.sv @@
`default_nettype none
module digw_match (
	input  wire digw_pkg::win_t                win,
	input  wire logic [digw_pkg::CNT_W-1:0]    fill,
	output digw_pkg::match_t                   res
);

	logic ok;

	always_comb begin
		res.res_byte = win[0];
		res.used     = digw_pkg::CNT_W'(1);
		for (int w = 0; w < digw_pkg::NUM_WORDS; w++) begin
			ok = (digw_pkg::WORD_LEN[w] <= fill);
			for (int k = 0; k < digw_pkg::WIN_DEPTH; k++) begin
				if (digw_pkg::CNT_W'(k) < digw_pkg::WORD_LEN[w] &&
				    digw_pkg::fold_case(win[k]) != digw_pkg::WORD_TAB[w][k]) begin
					ok = 1'b0;
				end
			end
			if (ok) begin
				res.res_byte = digw_pkg::DIGIT_BASE + 8'(w);
				res.used     = digw_pkg::WORD_LEN[w];
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/digit_word_substituter_core.sv @@
`default_nettype none
// Replaces the words zero..nine (any ASCII letter case) in a byte stream with the
// digits '0'..'9'; every other byte passes unchanged, tlast closes each line. Bytes
// enter a row of five cells; once five are held, or the line has ended, the head is
// decided and the row shifts by the bytes consumed. Input takes one byte per cycle
// while the row has room or the output is free; after the last byte of a line the row
// drains at one result per cycle (up to five) unless stalled, with s_axis_tready low.
module digit_word_substituter_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  wire logic       s_axis_tlast,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
	output logic            m_axis_tlast
);

	localparam int D = digw_pkg::WIN_DEPTH;
	localparam int CW = digw_pkg::CNT_W;

	digw_pkg::win_t      win;
	digw_pkg::match_t    mres;
	digw_pkg::cell_ctl_t ctl [D];
	logic [CW-1:0]       fill_q;
	logic                flush_q;
	logic [CW-1:0]       shift;
	logic [CW-1:0]       rem;
	logic                slot_free;
	logic                decide;
	logic                acc;

	assign slot_free     = !m_axis_tvalid || m_axis_tready;
	assign decide        = slot_free && (fill_q == CW'(D) || flush_q);
	assign s_axis_tready = !flush_q && (fill_q != CW'(D) || slot_free);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign shift         = decide ? mres.used : CW'(0);
	assign rem           = fill_q - shift;

	digw_match u_match (
		.win  (win),
		.fill (fill_q),
		.res  (mres)
	);

	for (genvar i = 0; i < D; i++) begin : g_cell
		logic [7:0] up1, up3, up4;
		assign up1 = (i + 1 < D) ? win[(i + 1) % D] : 8'h00;
		assign up3 = (i + 3 < D) ? win[(i + 3) % D] : 8'h00;
		assign up4 = (i + 4 < D) ? win[(i + 4) % D] : 8'h00;
		assign ctl[i].shift = shift;
		assign ctl[i].load  = acc && (rem == CW'(i));
		digw_cell u_cell (
			.clk     (clk),
			.ctl     (ctl[i]),
			.up1     (up1),
			.up3     (up3),
			.up4     (up4),
			.in_byte (s_axis_tdata),
			.byte_q  (win[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			flush_q       <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			fill_q <= rem + CW'(acc);
			if (acc && s_axis_tlast) begin
				flush_q <= 1'b1;
			end else if (decide && rem == CW'(0)) begin
				flush_q <= 1'b0;
			end
			if (decide) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (decide) begin
			m_axis_tdata <= mres.res_byte;
			m_axis_tlast <= flush_q && rem == CW'(0);
		end
	end

endmodule
`default_nettype wire

@@ tb/digit_word_substituter_core_test.sv @@
`timescale 1ns / 1ps

class digit_line_board;
	logic [7:0] window[$];
	logic [8:0] expected_q[$];
	int mismatches = 0;

	function string word_text(int w);
		case (w)
			0: return "zero";
			1: return "one";
			2: return "two";
			3: return "three";
			4: return "four";
			5: return "five";
			6: return "six";
			7: return "seven";
			8: return "eight";
			default: return "nine";
		endcase
	endfunction

	function logic [7:0] folded(logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c | 8'h20;
		end
		return c;
	endfunction

	function int head_word();
		string s;
		bit ok;
		for (int w = 0; w < 10; w++) begin
			s = word_text(w);
			if (s.len() <= window.size()) begin
				ok = 1'b1;
				for (int k = 0; k < s.len(); k++) begin
					if (folded(window[k]) != s[k]) begin
						ok = 1'b0;
					end
				end
				if (ok) begin
					return w;
				end
			end
		end
		return -1;
	endfunction

	function void decide_head(bit line_end);
		int w;
		string s;
		logic [7:0] data;
		w = head_word();
		if (w >= 0) begin
			s = word_text(w);
			data = digw_pkg::DIGIT_BASE + 8'(w);
			for (int k = 0; k < s.len(); k++) begin
				window.delete(0);
			end
		end else begin
			data = window.pop_front();
		end
		expected_q.push_back({line_end && window.size() == 0, data});
	endfunction

	function void note_byte(logic [7:0] data, bit line_end);
		window.push_back(data);
		if (!line_end) begin
			if (window.size() == 5) begin
				decide_head(1'b0);
			end
		end else begin
			while (window.size() > 0) begin
				decide_head(1'b1);
			end
		end
	endfunction

	function void check_byte(logic [7:0] data, logic line_end);
		logic [8:0] want;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("unexpected output transaction: byte %h last %b", data, line_end);
			end
			return;
		end
		want = expected_q.pop_front();
		if (data !== want[7:0] || line_end !== want[8]) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("output mismatch: expected byte %h last %b, got byte %h last %b",
					want[7:0], want[8], data, line_end);
			end
		end
	endfunction
endclass

module digit_word_substituter_core_test;
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	digit_line_board board = new();
	logic [7:0] line_bytes[$];
	int sent = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int hold_seq = 0;
	int hold_taken = 0;
	int hold_left = 0;

	digit_word_substituter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			board.check_byte(m_axis_tdata, m_axis_tlast);
		end
		if (hold_seq != hold_taken) begin
			hold_taken = hold_seq;
			hold_left = 200;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	function automatic logic [7:0] cased(logic [7:0] c);
		return $urandom_range(1) ? c - 8'h20 : c;
	endfunction

	task automatic make_line(int target);
		int pick;
		int w;
		int n;
		string s;
		string letters;
		letters = "zeroonetwthfuivsxgn";
		line_bytes.delete();
		while (line_bytes.size() < target) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				w = $urandom_range(9);
				s = board.word_text(w);
				n = (pick < 45) ? s.len() : $urandom_range(s.len() - 1, 1);
				for (int k = 0; k < n; k++) begin
					line_bytes.push_back(cased(s[k]));
				end
			end else if (pick < 80) begin
				line_bytes.push_back(cased(letters[$urandom_range(letters.len() - 1)]));
			end else if (pick < 92) begin
				line_bytes.push_back(8'($urandom_range(255)));
			end else begin
				case ($urandom_range(7))
					0: line_bytes.push_back(8'h40);
					1: line_bytes.push_back(8'h41);
					2: line_bytes.push_back(8'h5A);
					3: line_bytes.push_back(8'h5B);
					4: line_bytes.push_back(8'h7B);
					5: line_bytes.push_back(8'h00);
					6: line_bytes.push_back(8'hFF);
					default: line_bytes.push_back(8'hDA);
				endcase
			end
		end
	endtask

	task automatic send_line();
		bit line_end;
		for (int i = 0; i < line_bytes.size(); i++) begin
			line_end = (i == line_bytes.size() - 1);
			while ($urandom_range(99) < src_idle_pct) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= line_bytes[i];
			s_axis_tlast <= line_end;
			do @(posedge clk); while (!s_axis_tready);
			board.note_byte(line_bytes[i], line_end);
			sent++;
		end
	endtask

	task automatic send_text(string s);
		line_bytes.delete();
		for (int k = 0; k < s.len(); k++) begin
			line_bytes.push_back(s[k]);
		end
		send_line();
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (board.expected_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		src_idle_pct = 10;
		sink_idle_pct = 45;

		send_text("ZeRo");
		send_text("sEVENx");
		send_text("thre");
		line_bytes.delete();
		line_bytes.push_back(8'h00);
		line_bytes.push_back(8'hFF);
		send_line();
		send_text("Nine");
		send_text("eIGHT");
		wait_drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 10;
					sink_idle_pct = 45;
				end
				1: begin
					src_idle_pct = 45;
					sink_idle_pct = 10;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			if (phase == 0) begin
				hold_seq++;
				make_line(40);
				send_line();
			end
			while (sent < 25 + 160 * (phase + 1)) begin
				make_line(($urandom_range(7) == 0) ? $urandom_range(30, 12) : $urandom_range(8, 1));
				send_line();
			end
			wait_drain();
		end

		repeat (10) @(posedge clk);
		if (board.mismatches == 0 && board.expected_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end
endmodule

@@ sim.f @@
hdl/digw_pkg.sv
hdl/digw_cell.sv
hdl/digw_match.sv
hdl/digit_word_substituter_core.sv
tb/digit_word_substituter_core_test.sv
